// ===== rtl/core/opta_pkg.sv =====
`timescale 1ns / 1ps
// opta_pkg: sizes, codes, entry and result types and small helper functions
// for the oid prefix table attid mapper; depends on nothing
package opta_pkg;

   localparam int MAX_ENTRIES      = 64;
   localparam int MAX_PREFIX_BYTES = 16;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W  = 16;
   localparam int LEN_W = 5;
   localparam int PFX_W = 8 * MAX_PREFIX_BYTES;

   typedef enum logic [1:0] {
      OP_MAKE_ATTID   = 2'd0,
      OP_ATTID_TO_OID = 2'd1,
      OP_APPEND       = 2'd2,
      OP_CLEAR        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_ADDED     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_RESP
   } seq_state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PFX_W-1:0] prefix;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] attid;
      logic [5:0]  entry_index;
      logic [63:0] prefix_lo;
      logic [63:0] prefix_hi;
      logic [4:0]  prefix_len;
      logic [15:0] tail_bytes;
      logic [1:0]  tail_len;
   } result_type;

   // saturate the byte count to the table's prefix size
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = (len > LEN_W'(MAX_PREFIX_BYTES)) ? LEN_W'(MAX_PREFIX_BYTES) : len;
      return res;
   endfunction

   // keep only the bytes below the length, zero the rest
   function automatic logic [PFX_W-1:0] mask_prefix(input logic [63:0]      lo,
                                                    input logic [63:0]      hi,
                                                    input logic [LEN_W-1:0] len);
      logic [127:0]     full;
      logic [PFX_W-1:0] res;
      full = {hi, lo};
      res  = '0;
      for (int b = 0; b < MAX_PREFIX_BYTES; b++) begin
         if (LEN_W'(b) < len) begin
            res[8*b +: 8] = full[8*b +: 8];
         end
      end
      return res;
   endfunction

   // low half of the attribute id from the last sub-identifier
   function automatic logic [15:0] make_low(input logic [31:0] sub);
      logic [15:0] res;
      res = {|sub[31:14], 1'b0, sub[13:0]};
      return res;
   endfunction

   // ber tail from the low half, bits 15 and 14 stripped on the two-byte form
   function automatic logic [15:0] ber_tail(input logic [15:0] w);
      logic [15:0] res;
      if (w < 16'h0080) begin
         res = w;
      end else begin
         res = {1'b0, w[6:0], 1'b1, w[13:7]};
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/opta_if.sv =====
`timescale 1ns / 1ps
// opta_req_if and opta_rsp_if: valid/ready channels of the attid mapper
// widths come from the request and result formats; no package needed
interface opta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] prefix_lo;
   logic [63:0] prefix_hi;
   logic [4:0]  prefix_len;
   logic [31:0] last_arc;
   logic [31:0] attid_in;
   logic [15:0] entry_id;

   modport source (output valid, op, prefix_lo, prefix_hi, prefix_len, last_arc,
                   attid_in, entry_id,
                   input  ready);
   modport sink   (input  valid, op, prefix_lo, prefix_hi, prefix_len, last_arc,
                   attid_in, entry_id,
                   output ready);
endinterface

interface opta_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] attid_out;
   logic [5:0]  entry_index;
   logic [63:0] out_prefix_lo;
   logic [63:0] out_prefix_hi;
   logic [4:0]  out_prefix_len;
   logic [15:0] tail_bytes;
   logic [1:0]  tail_len;

   modport source (output valid, status, attid_out, entry_index, out_prefix_lo,
                   out_prefix_hi, out_prefix_len, tail_bytes, tail_len,
                   input  ready);
   modport sink   (input  valid, status, attid_out, entry_index, out_prefix_lo,
                   out_prefix_hi, out_prefix_len, tail_bytes, tail_len,
                   output ready);
endinterface

// ===== rtl/core/opta_ram.sv =====
`timescale 1ns / 1ps
// opta_ram: generic simple dual-port ram, one write and one registered read
// standalone, no package
module opta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/oid_prefix_table_attid_mapper.sv =====
`timescale 1ns / 1ps
// oid_prefix_table_attid_mapper: prefix table with make-attid, attid-to-oid,
// append and clear; uses opta_pkg, opta_if (channels) and opta_ram (table)
//
// channel   dir  modport   transfer when      payload
// req_ch    in   sink      valid && ready     op, prefix, prefix_len, last_arc,
//                                              attid_in, entry_id
// rsp_ch    out  source    valid && ready     status, attid_out, entry_index,
//                                              out_prefix, tail_bytes, tail_len
//
// timing: make attid and attid to oid walk the table ram port one entry per
//   cycle in table order and stop at the first match, else after the last
//   filled entry; append and clear skip the walk and go straight to the
//   response step
// one request at a time: req_ch.ready is high only while the sequencer idles
// the result sits in an output register, so the next request is taken while
//   it waits; a later result waits for rsp_ch to drain before it is loaded
// reset (synchronous) empties the table; the table ram itself is not cleared

module oid_prefix_table_attid_mapper (
   input logic         clock,
   input logic         reset,
   opta_req_if.sink    req_ch,
   opta_rsp_if.source  rsp_ch
);

   localparam int IDX_W = opta_pkg::IDX_W;
   localparam int CNT_W = opta_pkg::CNT_W;
   localparam int ID_W  = opta_pkg::ID_W;
   localparam int LEN_W = opta_pkg::LEN_W;
   localparam int PFX_W = opta_pkg::PFX_W;
   localparam int ENT_W = $bits(opta_pkg::entry_type);

   // sequencer
   opta_pkg::seq_state_type state_ff, state_in;

   // table occupancy
   logic [CNT_W-1:0] count_ff, count_in;

   // captured request
   opta_pkg::op_type  op_ff, op_in;
   logic [PFX_W-1:0]  pfx_ff, pfx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [15:0]       low_ff, low_in;
   logic [31:0]       attid_ff, attid_in;
   logic [ID_W-1:0]   eid_ff, eid_in;

   // scan walk: issue pointer, and the entry whose read data is back
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;

   // scan outcome
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   opta_pkg::entry_type  hit_data_ff, hit_data_in;
   logic [ID_W-1:0]      max_ff, max_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   opta_pkg::result_type rsp_ff, rsp_in;

   // table ram
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   opta_pkg::entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [ENT_W-1:0]    ram_rd_bits;
   opta_pkg::entry_type rd_entry;

   logic rsp_load;
   logic scan_hit;
   logic table_full;

   opta_ram #(
      .WIDTH (ENT_W),
      .DEPTH (opta_pkg::MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign rd_entry   = opta_pkg::entry_type'(ram_rd_bits);
   assign table_full = (count_ff >= CNT_W'(opta_pkg::MAX_ENTRIES));

   // the one shared comparator: prefix and length for make attid, id otherwise
   always_comb begin
      if (op_ff == opta_pkg::OP_MAKE_ATTID) begin
         scan_hit = chk_vld_ff && (rd_entry.len == len_ff) && (rd_entry.prefix == pfx_ff);
      end else begin
         scan_hit = chk_vld_ff && (rd_entry.id == attid_ff[31:16]);
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opta_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, datapath control and result composition
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      pfx_in       = pfx_ff;
      len_in       = len_ff;
      low_in       = low_ff;
      attid_in     = attid_ff;
      eid_in       = eid_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      hit_data_in  = hit_data_ff;
      max_in       = max_ff;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[IDX_W-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[IDX_W-1:0];
      rsp_load     = 1'b0;

      unique case (state_ff)
         opta_pkg::SEQ_IDLE: begin
            if (req_ch.valid) begin
               // capture with the length saturated and stray bytes zeroed
               op_in      = opta_pkg::op_type'(req_ch.op);
               len_in     = opta_pkg::clamp_len(req_ch.prefix_len);
               pfx_in     = opta_pkg::mask_prefix(req_ch.prefix_lo, req_ch.prefix_hi,
                                                  opta_pkg::clamp_len(req_ch.prefix_len));
               low_in     = opta_pkg::make_low(req_ch.last_arc);
               attid_in   = req_ch.attid_in;
               eid_in     = req_ch.entry_id;
               issue_in   = '0;
               hit_in     = 1'b0;
               max_in     = '0;
               if (opta_pkg::op_type'(req_ch.op) == opta_pkg::OP_MAKE_ATTID ||
                   opta_pkg::op_type'(req_ch.op) == opta_pkg::OP_ATTID_TO_OID) begin
                  state_in = opta_pkg::SEQ_SCAN;
               end else begin
                  state_in = opta_pkg::SEQ_RESP;
               end
            end
         end

         opta_pkg::SEQ_SCAN: begin
            if (scan_hit) begin
               // first match in table order ends the walk
               hit_in      = 1'b1;
               pos_in      = chk_idx_ff;
               hit_data_in = rd_entry;
               state_in    = opta_pkg::SEQ_RESP;
            end else begin
               // running maximum of the ids seen, for a possible new entry in make attid
               if (chk_vld_ff && rd_entry.id > max_ff) begin
                  max_in = rd_entry.id;
               end
               if (issue_ff < count_ff) begin
                  ram_rd_en  = 1'b1;
                  chk_vld_in = 1'b1;
                  chk_idx_in = issue_ff[IDX_W-1:0];
                  issue_in   = CNT_W'(issue_ff + 1'b1);
               end else if (!chk_vld_ff) begin
                  // every entry checked, none matched
                  state_in = opta_pkg::SEQ_RESP;
               end
            end
         end

         opta_pkg::SEQ_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = opta_pkg::SEQ_IDLE;
               rsp_in   = '0;
               unique case (op_ff)
                  opta_pkg::OP_MAKE_ATTID: begin
                     if (hit_ff) begin
                        rsp_in.status      = opta_pkg::ST_FOUND;
                        rsp_in.attid       = {hit_data_ff.id, low_ff};
                        rsp_in.entry_index = 6'(pos_ff);
                     end else if (table_full || max_ff == {ID_W{1'b1}}) begin
                        // table full or id overflow, table unchanged
                        rsp_in.status = opta_pkg::ST_FULL;
                     end else begin
                        ram_wr_en          = 1'b1;
                        ram_wr_data.id     = ID_W'(max_ff + 1'b1);
                        ram_wr_data.prefix = pfx_ff;
                        ram_wr_data.len    = len_ff;
                        count_in           = CNT_W'(count_ff + 1'b1);
                        rsp_in.status      = opta_pkg::ST_ADDED;
                        rsp_in.attid       = {ID_W'(max_ff + 1'b1), low_ff};
                        rsp_in.entry_index = 6'(count_ff);
                     end
                  end
                  opta_pkg::OP_ATTID_TO_OID: begin
                     if (hit_ff) begin
                        rsp_in.status      = opta_pkg::ST_FOUND;
                        rsp_in.entry_index = 6'(pos_ff);
                        rsp_in.prefix_lo   = hit_data_ff.prefix[63:0];
                        rsp_in.prefix_hi   = hit_data_ff.prefix[PFX_W-1:64];
                        rsp_in.prefix_len  = hit_data_ff.len;
                        rsp_in.tail_bytes  = opta_pkg::ber_tail(attid_ff[15:0]);
                        rsp_in.tail_len    = (attid_ff[15:0] < 16'h0080) ? 2'd1 : 2'd2;
                     end else begin
                        rsp_in.status = opta_pkg::ST_NOT_FOUND;
                     end
                  end
                  opta_pkg::OP_APPEND: begin
                     if (table_full) begin
                        rsp_in.status = opta_pkg::ST_FULL;
                     end else begin
                        ram_wr_en          = 1'b1;
                        ram_wr_data.id     = eid_ff;
                        ram_wr_data.prefix = pfx_ff;
                        ram_wr_data.len    = len_ff;
                        count_in           = CNT_W'(count_ff + 1'b1);
                        rsp_in.status      = opta_pkg::ST_ADDED;
                        rsp_in.entry_index = 6'(count_ff);
                     end
                  end
                  opta_pkg::OP_CLEAR: begin
                     count_in      = '0;
                     rsp_in.status = opta_pkg::ST_FOUND;
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end

         default: begin
            state_in = opta_pkg::SEQ_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pfx_ff      <= pfx_in;
      len_ff      <= len_in;
      low_ff      <= low_in;
      attid_ff    <= attid_in;
      eid_ff      <= eid_in;
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      hit_data_ff <= hit_data_in;
      max_ff      <= max_in;
      rsp_ff      <= rsp_in;
   end

   // no request is taken while reset is held
   assign req_ch.ready = (state_ff == opta_pkg::SEQ_IDLE) && !reset;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.attid_out      = rsp_ff.attid;
   assign rsp_ch.entry_index    = rsp_ff.entry_index;
   assign rsp_ch.out_prefix_lo  = rsp_ff.prefix_lo;
   assign rsp_ch.out_prefix_hi  = rsp_ff.prefix_hi;
   assign rsp_ch.out_prefix_len = rsp_ff.prefix_len;
   assign rsp_ch.tail_bytes     = rsp_ff.tail_bytes;
   assign rsp_ch.tail_len       = rsp_ff.tail_len;

   // occupancy never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(opta_pkg::MAX_ENTRIES))
      else $error("entry count beyond table depth");

   // an entry under check always lies inside the filled part of the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == opta_pkg::SEQ_SCAN && chk_vld_ff) |-> (chk_idx_ff < count_ff))
      else $error("scan checks an entry past the fill count");

   // the table only grows or empties when a result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> $past(rsp_load))
      else $error("entry count moved without a result");

   // a new result appears only out of the response step
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == opta_pkg::SEQ_RESP))
      else $error("result raised outside the response step");

endmodule
